// ----- hdl/cfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

	localparam int VARS_DEF    = 16;
	localparam int Q_W         = 32;
	localparam int FRAC_W      = 16;
	localparam int IDX_IN_W    = 4;
	localparam int VC_W        = 5;
	localparam int TOL_W       = 16;
	localparam int DIV_STEPS   = Q_W;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 8;

	localparam logic [0:0] REG_VAR_COUNT = 1'b0;
	localparam logic [0:0] REG_TOLERANCE = 1'b1;

	localparam logic [VC_W-1:0] VAR_COUNT_RST = 5'd16;

	localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic load;
		logic upper;
		logic upd;
		logic chk;
		logic clr;
	} bnd_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/cfc_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_regs import cfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [VC_W-1:0]   var_count,
	output logic [TOL_W-1:0]  tolerance
);

	logic [VC_W-1:0]  var_count_q;
	logic [TOL_W-1:0] tolerance_q;
	logic [0:0]       reg_idx;
	logic             wr_en;

	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_count_q <= VAR_COUNT_RST;
			tolerance_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_VAR_COUNT: var_count_q <= pwdata[VC_W-1:0];
				REG_TOLERANCE: tolerance_q <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VAR_COUNT: prdata = {{(APB_DW-VC_W){1'b0}}, var_count_q};
			REG_TOLERANCE: prdata = {{(APB_DW-TOL_W){1'b0}}, tolerance_q};
			default:       prdata = '0;
		endcase
	end

	assign var_count = var_count_q;
	assign tolerance = tolerance_q;

endmodule

`default_nettype wire

// ----- hdl/cfc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_div import cfc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [Q_W-1:0] dividend,
	input  logic [Q_W-1:0] divisor,
	output logic           done,
	output logic [Q_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_state_t;

	dv_state_t      state_q;
	logic [CNT_W-1:0] cnt_q;
	logic           done_q;
	logic [Q_W-1:0] mag_a_q;
	logic [Q_W-1:0] rem_q;
	logic [Q_W-1:0] dvd_q;
	logic [Q_W-1:0] quot_q;
	logic           neg_q;
	logic           ovf_q;

	logic [Q_W-1:0] mag_a;
	logic [Q_W-1:0] mag_b;
	logic [Q_W-1:0] rem_init;
	logic [Q_W:0]   trial;
	logic           pos_sat;
	logic           neg_sat;
	logic [Q_W-1:0] quot_next;

	assign mag_a    = divisor[Q_W-1] ? (~divisor + 1'b1) : divisor;
	assign mag_b    = dividend[Q_W-1] ? (~dividend + 1'b1) : dividend;
	assign rem_init = {{FRAC_W{1'b0}}, mag_b[Q_W-1:FRAC_W]};
	assign trial    = {rem_q, dvd_q[Q_W-1]} - {1'b0, mag_a_q};

	// quotient magnitude of 2^32 or more was flagged at start
	assign pos_sat   = ovf_q || dvd_q[Q_W-1];
	assign neg_sat   = ovf_q || (dvd_q[Q_W-1] && (|dvd_q[Q_W-2:0]));
	assign quot_next = neg_q ? (neg_sat ? Q_MIN : (~dvd_q + 1'b1))
	                         : (pos_sat ? Q_MAX : dvd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DV_IDLE: begin
					if (start) begin
						state_q <= DV_RUN;
						cnt_q   <= '0;
					end
				end
				DV_RUN: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= DV_FIN;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				DV_FIN: begin
					state_q <= DV_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= DV_IDLE;
			endcase
		end
	end

	// restoring division, one quotient bit shifted into dvd_q per cycle
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			mag_a_q <= mag_a;
			rem_q   <= rem_init;
			dvd_q   <= {mag_b[FRAC_W-1:0], {(Q_W-FRAC_W){1'b0}}};
			neg_q   <= dividend[Q_W-1] ^ divisor[Q_W-1];
			ovf_q   <= (rem_init >= mag_a);
		end else if (state_q == DV_RUN) begin
			if (!trial[Q_W]) begin
				rem_q <= trial[Q_W-1:0];
			end else begin
				rem_q <= {rem_q[Q_W-2:0], dvd_q[Q_W-1]};
			end
			dvd_q <= {dvd_q[Q_W-2:0], ~trial[Q_W]};
		end else if (state_q == DV_FIN) begin
			quot_q <= quot_next;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

// ----- hdl/cfc_bounds.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_bounds import cfc_pkg::*; #(
	parameter  int VARS  = VARS_DEF,
	localparam int IDX_W = (VARS > 1) ? $clog2(VARS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bnd_ctrl_t        ctrl,
	input  logic [IDX_W-1:0] idx,
	input  logic [Q_W-1:0]   q,
	input  logic [TOL_W-1:0] tolerance,
	output logic             conflict
);

	logic [Q_W-1:0] lower_mem [VARS];
	logic [Q_W-1:0] upper_mem [VARS];

	logic [IDX_W-1:0] idx_q;
	logic             upper_q;
	logic [Q_W-1:0]   rd_lo_q;
	logic [Q_W-1:0]   rd_hi_q;
	logic [Q_W-1:0]   new_lo_q;
	logic [Q_W-1:0]   new_hi_q;
	logic [VARS-1:0]  lo_known_q;
	logic [VARS-1:0]  hi_known_q;
	logic             conflict_q;

	logic             take_lo;
	logic             take_hi;
	logic [Q_W+1:0]   hi_plus_tol;
	logic             gt;

	assign take_hi = !hi_known_q[idx_q] || ($signed(q) < $signed(rd_hi_q));
	assign take_lo = !lo_known_q[idx_q] || ($signed(q) > $signed(rd_lo_q));

	assign hi_plus_tol = {{2{new_hi_q[Q_W-1]}}, new_hi_q}
	                   + {{(Q_W+2-TOL_W){1'b0}}, tolerance};
	assign gt = $signed({{2{new_lo_q[Q_W-1]}}, new_lo_q}) > $signed(hi_plus_tol);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			idx_q   <= idx;
			upper_q <= ctrl.upper;
		end
		rd_lo_q <= lower_mem[idx_q];
		rd_hi_q <= upper_mem[idx_q];
		if (ctrl.upd) begin
			if (upper_q && take_hi) begin
				upper_mem[idx_q] <= q;
			end
			if (!upper_q && take_lo) begin
				lower_mem[idx_q] <= q;
			end
			new_hi_q <= (upper_q && take_hi) ? q : rd_hi_q;
			new_lo_q <= (!upper_q && take_lo) ? q : rd_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_known_q <= '0;
			hi_known_q <= '0;
			conflict_q <= 1'b0;
		end else if (ctrl.clr) begin
			lo_known_q <= '0;
			hi_known_q <= '0;
			conflict_q <= 1'b0;
		end else begin
			if (ctrl.upd) begin
				if (upper_q) begin
					hi_known_q[idx_q] <= 1'b1;
				end else begin
					lo_known_q[idx_q] <= 1'b1;
				end
			end
			if (ctrl.chk && lo_known_q[idx_q] && hi_known_q[idx_q] && gt) begin
				conflict_q <= 1'b1;
			end
		end
	end

	assign conflict = conflict_q;

endmodule

`default_nettype wire

// ----- hdl/constraint_feasibility_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streams nonzero elements of a linear inequality set (variable index, Q16.16
// coefficient a, Q16.16 row bound b) and tracks per-variable bounds from
// q = b/a (truncated, saturated): positive a tightens the upper bound, negative
// a the lower one. Zero coefficients and indices at or beyond var_count are
// ignored. The element with tlast set yields one result, feasible = 1 unless
// some variable ended up with lower > upper + tolerance, and clears all bounds.
// A usable element blocks acceptance until it is through: it waits on the
// bit-serial divider (32 quotient bits, one per cycle, then sign and
// saturation and the registered done handoff), then bound read-modify-write,
// conflict check, wrap-up and a return to idle with tready up. An ignored
// element skips the divider and goes to wrap-up. A last element holds until
// the output register is free. No clearing pass after reset.

module constraint_feasibility_check import cfc_pkg::*; #(
	parameter int VARS = VARS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_AW-1:0]      paddr,
	input  logic [APB_DW-1:0]      pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// var_index[3:0], coefficient[35:4], row_bound[67:36], zero pad[71:68]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// feasible[0], zero pad[7:1]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W   = (VARS > 1) ? $clog2(VARS) : 1;
	localparam int COEF_LO = IDX_IN_W;
	localparam int BND_LO  = IDX_IN_W + Q_W;

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_UPD, ST_CHK, ST_DONE} state_t;

	state_t state_q;
	logic   last_q;
	logic   out_valid_q;
	logic   out_feasible_q;

	logic [VC_W-1:0]     var_count;
	logic [TOL_W-1:0]    tolerance;
	logic [IDX_IN_W-1:0] s_idx;
	logic [Q_W-1:0]      s_coef;
	logic [Q_W-1:0]      s_bnd;
	logic                accept;
	logic                usable;
	logic                slot_free;
	logic                div_done;
	logic [Q_W-1:0]      div_q;
	logic                conflict;
	bnd_ctrl_t           ctrl;

	assign s_idx  = s_tdata[IDX_IN_W-1:0];
	assign s_coef = s_tdata[COEF_LO +: Q_W];
	assign s_bnd  = s_tdata[BND_LO +: Q_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign usable    = (s_coef != '0) && ({1'b0, s_idx} < var_count)
	                && (32'(s_idx) < VARS);
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		ctrl       = '0;
		ctrl.load  = accept && usable;
		ctrl.upper = !s_coef[Q_W-1];
		ctrl.upd   = (state_q == ST_UPD);
		ctrl.chk   = (state_q == ST_CHK);
		ctrl.clr   = (state_q == ST_DONE) && last_q && slot_free;
	end

	cfc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.var_count (var_count),
		.tolerance (tolerance)
	);

	cfc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.load),
		.dividend (s_bnd),
		.divisor  (s_coef),
		.done     (div_done),
		.quotient (div_q)
	);

	cfc_bounds #(
		.VARS (VARS)
	) u_bounds (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.idx       (IDX_W'(s_idx)),
		.q         (div_q),
		.tolerance (tolerance),
		.conflict  (conflict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			last_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			out_feasible_q <= 1'b0;
		end else begin
			if (ctrl.clr) begin
				out_valid_q    <= 1'b1;
				out_feasible_q <= !conflict;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q  <= s_tlast;
						state_q <= usable ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: state_q <= ST_CHK;
				ST_CHK: state_q <= ST_DONE;
				ST_DONE: begin
					if (!last_q || slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_feasible_q};

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide phase");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past((state_q == ST_DONE) && last_q))
		else $error("result raised without a last element");

	a_skip_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !usable) |=> (state_q == ST_DONE))
		else $error("ignored element entered the divide path");

	a_clear_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr |=> !conflict)
		else $error("conflict flag survived end of set");

endmodule

`default_nettype wire
